@@ rtl/bbtm_pkg.sv @@
package bbtm_pkg;

   localparam int NUM_BUFFERS = 32;
   localparam int IDX_W       = $clog2(NUM_BUFFERS);
   localparam int FC_W        = $clog2(NUM_BUFFERS + 1);
   localparam int CNT_W       = 8;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_UNPIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISS     = 2'd1,
      ST_NOFREE   = 2'd2,
      ST_UNLISTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_SEL,
      S_POP,
      S_RD
   } state_type;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

endpackage

@@ rtl/bbtm_if.sv @@
interface bbtm_req_if
   import bbtm_pkg::*;
();
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  device;
   logic [31:0] block_number;
   logic [4:0]  buffer_index;

   modport source (output valid, kind, device, block_number, buffer_index, input ready);
   modport sink   (input valid, kind, device, block_number, buffer_index, output ready);
endinterface

interface bbtm_rsp_if
   import bbtm_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [4:0]  result_buffer;
   status_type  status;
   logic [7:0]  reference_count;

   modport source (output valid, result_buffer, status, reference_count, input ready);
   modport sink   (input valid, result_buffer, status, reference_count, output ready);
endinterface

@@ rtl/block_buffer_tag_manager_unit.sv @@
// block buffer tag manager
// req channel carries get, release, pin and unpin requests; rsp channel returns
// one result per request: buffer, status and reference count after the request.
// one request is worked on at a time. steps from accept to rsp valid:
//   get hit: tag compare, match select, count memory read
//   get miss: tag compare, match select, free stack memory read
//   get with no free buffer: tag compare, match select
//   release, pin, unpin: count memory read
// with rsp ready the next request is taken in the cycle after the result is loaded.
// the counts and the free stack sit in single port synchronous memories; for
// release, pin and unpin the count read-modify-write sets the per request time.
// a new request is taken as soon as the previous one has been written to the
// output register, even if that result is still waiting on rsp.
// if rsp stalls with a result pending, the next request finishes its work
// and then holds until the output register frees up.
// reset (synchronous) empties the pool: nothing listed, all counts zero and the
// free stack full with buffer NUM_BUFFERS-1 on top. no clearing pass is needed.
module block_buffer_tag_manager_unit
   import bbtm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   bbtm_req_if.sink      req,
   bbtm_rsp_if.source    rsp
);

   state_type   state_ff, state_in;
   kind_type    kind_ff;
   logic [7:0]  dev_ff;
   logic [31:0] blk_ff;
   logic [4:0]  bidx_ff;
   idx_type     idx_ff, idx_in;
   logic        oor_ff;

   logic [NUM_BUFFERS-1:0] match_ff;
   logic [NUM_BUFFERS-1:0] listed_ff;
   logic [NUM_BUFFERS-1:0] valid_ff;
   logic [NUM_BUFFERS-1:0] cvld_ff;
   logic [NUM_BUFFERS-1:0] swr_ff;
   logic [7:0]             tag_dev_ff [NUM_BUFFERS];
   logic [31:0]            tag_blk_ff [NUM_BUFFERS];
   logic [FC_W-1:0]        free_cnt_ff;
   idx_type                stk_addr_ff;

   cnt_type cnt_mem [NUM_BUFFERS];
   cnt_type cnt_q;
   idx_type stk_mem [NUM_BUFFERS];
   idx_type stk_q;

   logic        rsp_valid_ff;
   logic [4:0]  rsp_buf_ff, rsp_buf_in;
   status_type  rsp_st_ff, rsp_st_in;
   cnt_type     rsp_cnt_ff, rsp_cnt_in;
   logic        out_load;

   logic    cnt_re, cnt_we, stk_re, stk_we;
   idx_type cnt_ra, cnt_wa, stk_ra, stk_wa, stk_wd;
   cnt_type cnt_wd;
   logic    alloc, list_clr, valid_set, fc_inc, fc_dec;
   idx_type upd_idx;

   logic    accept, out_free, hit;
   idx_type enc, pop_idx;
   cnt_type cur_cnt, inc_cnt, dec_cnt;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign hit      = |match_ff;
   assign pop_idx  = swr_ff[stk_addr_ff] ? stk_q : stk_addr_ff;
   assign cur_cnt  = cvld_ff[idx_ff] ? cnt_q : '0;
   assign inc_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
   assign dec_cnt  = (cur_cnt == '0) ? cur_cnt : cur_cnt - 1'b1;

   always_comb begin
      enc = '0;
      for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            enc = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req.ready  = 1'b0;
      cnt_re     = 1'b0;
      cnt_ra     = '0;
      cnt_we     = 1'b0;
      cnt_wa     = idx_ff;
      cnt_wd     = '0;
      stk_re     = 1'b0;
      stk_ra     = IDX_W'(free_cnt_ff - 1'b1);
      stk_we     = 1'b0;
      stk_wa     = IDX_W'(free_cnt_ff);
      stk_wd     = idx_ff;
      alloc      = 1'b0;
      list_clr   = 1'b0;
      valid_set  = 1'b0;
      fc_inc     = 1'b0;
      fc_dec     = 1'b0;
      upd_idx    = idx_ff;
      out_load   = 1'b0;
      rsp_buf_in = 5'(idx_ff);
      rsp_st_in  = ST_OK;
      rsp_cnt_in = '0;
      unique case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.kind == KIND_GET) begin
                  state_in = S_MATCH;
               end else begin
                  idx_in   = IDX_W'(req.buffer_index);
                  cnt_re   = 1'b1;
                  cnt_ra   = IDX_W'(req.buffer_index);
                  state_in = S_RD;
               end
            end
         end
         S_MATCH: begin
            state_in = S_SEL;
         end
         S_SEL: begin
            if (hit) begin
               idx_in   = enc;
               cnt_re   = 1'b1;
               cnt_ra   = enc;
               state_in = S_RD;
            end else if (free_cnt_ff == '0) begin
               if (out_free) begin
                  out_load   = 1'b1;
                  rsp_buf_in = '0;
                  rsp_st_in  = ST_NOFREE;
                  rsp_cnt_in = '0;
                  state_in   = S_IDLE;
               end
            end else begin
               stk_re   = 1'b1;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (out_free) begin
               alloc      = 1'b1;
               upd_idx    = pop_idx;
               cnt_we     = 1'b1;
               cnt_wa     = pop_idx;
               cnt_wd     = cnt_type'(1);
               fc_dec     = 1'b1;
               out_load   = 1'b1;
               rsp_buf_in = 5'(pop_idx);
               rsp_st_in  = ST_MISS;
               rsp_cnt_in = cnt_type'(1);
               state_in   = S_IDLE;
            end
         end
         S_RD: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               if (oor_ff) begin
                  rsp_buf_in = bidx_ff;
                  rsp_st_in  = ST_UNLISTED;
                  rsp_cnt_in = '0;
               end else begin
                  unique case (kind_ff)
                     KIND_GET: begin
                        rsp_st_in  = valid_ff[idx_ff] ? ST_OK : ST_MISS;
                        cnt_we     = 1'b1;
                        cnt_wd     = inc_cnt;
                        valid_set  = 1'b1;
                        rsp_cnt_in = inc_cnt;
                     end
                     KIND_RELEASE: begin
                        if (!listed_ff[idx_ff]) begin
                           rsp_st_in  = ST_UNLISTED;
                           rsp_cnt_in = cur_cnt;
                        end else begin
                           cnt_we     = 1'b1;
                           cnt_wd     = dec_cnt;
                           rsp_cnt_in = dec_cnt;
                           if (dec_cnt == '0 && free_cnt_ff < FC_W'(NUM_BUFFERS)) begin
                              list_clr = 1'b1;
                              stk_we   = 1'b1;
                              fc_inc   = 1'b1;
                           end
                        end
                     end
                     KIND_PIN: begin
                        cnt_we     = 1'b1;
                        cnt_wd     = inc_cnt;
                        rsp_cnt_in = inc_cnt;
                     end
                     KIND_UNPIN: begin
                        cnt_we     = 1'b1;
                        cnt_wd     = dec_cnt;
                        rsp_cnt_in = dec_cnt;
                     end
                     default: begin
                        rsp_cnt_in = cur_cnt;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         listed_ff    <= '0;
         valid_ff     <= '0;
         cvld_ff      <= '0;
         swr_ff       <= '0;
         free_cnt_ff  <= FC_W'(NUM_BUFFERS);
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (alloc) begin
            listed_ff[upd_idx] <= 1'b1;
            valid_ff[upd_idx]  <= 1'b1;
         end
         if (valid_set) begin
            valid_ff[upd_idx] <= 1'b1;
         end
         if (list_clr) begin
            listed_ff[upd_idx] <= 1'b0;
         end
         if (cnt_we) begin
            cvld_ff[cnt_wa] <= 1'b1;
         end
         if (stk_we) begin
            swr_ff[stk_wa] <= 1'b1;
         end
         if (fc_inc) begin
            free_cnt_ff <= free_cnt_ff + 1'b1;
         end else if (fc_dec) begin
            free_cnt_ff <= free_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req.kind;
         dev_ff  <= req.device;
         blk_ff  <= req.block_number;
         bidx_ff <= req.buffer_index;
         oor_ff  <= (req.kind != KIND_GET) && (int'(req.buffer_index) >= NUM_BUFFERS);
      end
      idx_ff <= idx_in;
      if (stk_re) begin
         stk_addr_ff <= stk_ra;
      end
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         match_ff[i] <= listed_ff[i] && (tag_dev_ff[i] == dev_ff) && (tag_blk_ff[i] == blk_ff);
      end
      if (alloc) begin
         tag_dev_ff[upd_idx] <= dev_ff;
         tag_blk_ff[upd_idx] <= blk_ff;
      end
      if (out_load) begin
         rsp_buf_ff <= rsp_buf_in;
         rsp_st_ff  <= rsp_st_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_q <= cnt_mem[cnt_ra];
      end
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_q <= stk_mem[stk_ra];
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.result_buffer   = rsp_buf_ff;
   assign rsp.status          = rsp_st_ff;
   assign rsp.reference_count = rsp_cnt_ff;

endmodule

@@ rtl/bbtm_checker.sv @@
module bbtm_checker
   import bbtm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_result_buffer,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_reference_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_buffer) && $stable(rsp_status)
         && $stable(rsp_reference_count))
      else $error("rsp payload changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_nofree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOFREE |-> rsp_reference_count == 8'd0
         && rsp_result_buffer == 5'd0)
      else $error("no free result with nonzero fields");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MISS |-> rsp_reference_count != 8'd0)
      else $error("miss with zero count");

endmodule

bind block_buffer_tag_manager_unit bbtm_checker u_bbtm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_result_buffer   (rsp.result_buffer),
   .rsp_status          (rsp.status),
   .rsp_reference_count (rsp.reference_count)
);
